@@ hdl/cursor_text_buffer_macros.svh @@
// Assertion macros shared by the cursor text buffer RTL.
`ifndef CURSOR_TEXT_BUFFER_MACROS_SVH
`define CURSOR_TEXT_BUFFER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cursor_text_buffer: assertion failed");

// Next-cycle implication, checked outside reset.
`define CTB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cursor_text_buffer: assertion failed");

`endif

@@ hdl/ctb_pkg.sv @@
// Types and constants of the cursor text buffer.
`default_nettype none

package ctb_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    CMD_FORWARD  = 3'd0,
    CMD_BACKWARD = 3'd1,
    CMD_START    = 3'd2,
    CMD_END      = 3'd3,
    CMD_INSERT   = 3'd4,
    CMD_DELETE   = 3'd5,
    CMD_READ     = 3'd6
  } ctb_cmd_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_in;
    logic [5:0] read_index;
  } ctb_req_t;

  typedef struct packed {
    logic [6:0] cursor_pos;
    logic [6:0] text_length;
    logic [7:0] read_char;
    logic       dropped;
  } ctb_rsp_t;

endpackage

`default_nettype wire

@@ hdl/cursor_text_buffer.sv @@
// Cursor text buffer: byte store with cursor, insert/delete shift walk in one RAM.
//
//  channel   | ports                      | handshake
//  ----------+----------------------------+--------------------------------------
//  command   | start, busy, req_i         | transaction when start && !busy
//  result    | rsp_valid_o, rsp_o         | one-cycle strobe, no back-pressure
//
// Cursor moves, jumps, unknown codes, refused inserts, deletes at the end and
// reads at or past the length: result in the cycle after the transaction. A
// read below the length passes through the RAM read register and then the
// result register. Insert and delete walk the bytes behind the cursor through
// the single RAM, one entry per cycle with read and write overlapped, then
// drain the last write-back and then place the byte or shrink; when no byte
// has to move, the walk and the drain are skipped. Reset clears cursor and
// length at once; the RAM needs no clearing pass, since only entries below
// the length are ever read.
// The result port cannot stall; busy holds off new commands during a walk or a RAM read.
`default_nettype none
`include "cursor_text_buffer_macros.svh"

module cursor_text_buffer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire ctb_pkg::ctb_req_t req_i,
  output logic                   rsp_valid_o,
  output ctb_pkg::ctb_rsp_t      rsp_o
);
  import ctb_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SHIFT  = 3'b010,
    ST_RDWAIT = 3'b100
  } ctb_state_e;

  ctb_state_e state_q, state_d;

  // Architectural state.
  logic [CntW-1:0]  cursor_q, cursor_d;
  logic [CntW-1:0]  len_q, len_d;

  // Walk pointer and the one outstanding write-back.
  logic [CntW-1:0]  ptr_q, ptr_d;
  logic             pend_q, pend_d;
  logic [AddrW-1:0] pend_addr_q, pend_addr_d;

  // Latched command of the transaction in flight.
  logic             ins_q, ins_d;
  logic [7:0]       ch_q, ch_d;

  // Result register.
  logic             rsp_valid_q, rsp_valid_d;
  ctb_rsp_t         rsp_q, rsp_d;
  logic [7:0]       rchar;
  logic             drop;

  // Text RAM, one read and one write port, registered read data.
  logic [7:0]       mem_q [Capacity];
  logic             rd_en;
  logic [AddrW-1:0] raddr;
  logic [7:0]       rdata_q;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [7:0]       wdata;

  logic             more;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    len_d       = len_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    ins_d       = ins_q;
    ch_d        = ch_q;
    rsp_valid_d = 1'b0;
    rchar       = 8'd0;
    drop        = 1'b0;
    rd_en       = 1'b0;
    raddr       = '0;
    we          = 1'b0;
    waddr       = pend_addr_q;
    wdata       = rdata_q;
    more        = 1'b0;

    // Drain the write-back of the entry read last cycle.
    if (pend_q) begin
      we = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          ch_d = req_i.char_in;
          unique case (ctb_cmd_e'(req_i.cmd))
            CMD_FORWARD: begin
              if (cursor_q < len_q) cursor_d = cursor_q + CntW'(1);
              rsp_valid_d = 1'b1;
            end
            CMD_BACKWARD: begin
              if (cursor_q != '0) cursor_d = cursor_q - CntW'(1);
              rsp_valid_d = 1'b1;
            end
            CMD_START: begin
              cursor_d    = '0;
              rsp_valid_d = 1'b1;
            end
            CMD_END: begin
              cursor_d    = len_q;
              rsp_valid_d = 1'b1;
            end
            CMD_INSERT: begin
              if (len_q >= CntW'(Capacity)) begin
                drop        = 1'b1;
                rsp_valid_d = 1'b1;
              end else begin
                // Walk down from the end, moving each byte up one slot.
                ins_d   = 1'b1;
                ptr_d   = len_q;
                state_d = ST_SHIFT;
              end
            end
            CMD_DELETE: begin
              if (cursor_q < len_q) begin
                // Walk up from behind the cursor, moving each byte down.
                ins_d   = 1'b0;
                ptr_d   = cursor_q + CntW'(1);
                state_d = ST_SHIFT;
              end else begin
                rsp_valid_d = 1'b1;
              end
            end
            CMD_READ: begin
              if (CntW'(req_i.read_index) < len_q) begin
                rd_en   = 1'b1;
                raddr   = AddrW'(req_i.read_index);
                state_d = ST_RDWAIT;
              end else begin
                rsp_valid_d = 1'b1;
              end
            end
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        more = ins_q ? (ptr_q > cursor_q) : (ptr_q < len_q);
        if (more) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          if (ins_q) begin
            raddr       = AddrW'(ptr_q - CntW'(1));
            pend_addr_d = AddrW'(ptr_q);
            ptr_d       = ptr_q - CntW'(1);
          end else begin
            raddr       = AddrW'(ptr_q);
            pend_addr_d = AddrW'(ptr_q - CntW'(1));
            ptr_d       = ptr_q + CntW'(1);
          end
        end else if (!pend_q) begin
          // Walk drained: place the byte or shrink, then report.
          if (ins_q) begin
            we       = 1'b1;
            waddr    = AddrW'(cursor_q);
            wdata    = ch_q;
            len_d    = len_q + CntW'(1);
            cursor_d = cursor_q + CntW'(1);
          end else begin
            len_d = len_q - CntW'(1);
          end
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_RDWAIT: begin
        rchar       = rdata_q;
        rsp_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    rsp_d.cursor_pos  = 7'(cursor_d);
    rsp_d.text_length = 7'(len_d);
    rsp_d.read_char   = rchar;
    rsp_d.dropped     = drop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      len_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      len_q       <= len_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    pend_addr_q <= pend_addr_d;
    ins_q       <= ins_d;
    ch_q        <= ch_d;
    rsp_q       <= rsp_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `CTB_ASSERT_IMP(a_cursor_le_len, clk_i, rst_ni, 1'b1, cursor_q <= len_q)
  `CTB_ASSERT_IMP(a_len_le_cap, clk_i, rst_ni, 1'b1, len_q <= CntW'(Capacity))
  `CTB_ASSERT_IMP(a_rsp_in_idle, clk_i, rst_ni, rsp_valid_q, state_q == ST_IDLE)
  `CTB_ASSERT_IMP(a_pend_in_shift, clk_i, rst_ni, pend_q, state_q == ST_SHIFT)
  `CTB_ASSERT_NXT(a_start_answered, clk_i, rst_ni, start && !busy, rsp_valid_q || (state_q != ST_IDLE))

endmodule

`default_nettype wire
